>>> sv/quad_strip_span_rasterizer_core_macros.svh
// Assertion helpers shared by the span walker.
`ifndef QUAD_STRIP_SPAN_RASTERIZER_CORE_MACROS_SVH
`define QUAD_STRIP_SPAN_RASTERIZER_CORE_MACROS_SVH

// Check a condition at every edge outside reset.
`define QSSR_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another on the same edge.
`define QSSR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> sv/qssr_pkg.sv
package qssr_pkg;

   // request type codes on the input channel
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_EDGE  = 2'd1;
   localparam logic [1:0] REQ_ROW   = 2'd2;

   // configuration register indexes (paddr[2])
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd320;
   localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd200;
   localparam logic [10:0] DIM_MIN = 11'd1;
   localparam logic [10:0] DIM_MAX = 11'd1024;

   // reciprocal numerator and its bit count
   localparam int          DIV_BITS     = 15;
   localparam logic [14:0] DIV_DIVIDEND = 15'h4000;

   localparam logic [31:0] ACC_INT_MASK = 32'hFFFF0000;
   localparam logic [15:0] LEFT_FRAC    = 16'h7FFF;
   localparam logic [15:0] RIGHT_FRAC   = 16'h8000;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_BEGIN,
      OP_EDGE,
      OP_ROW,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [5:0]  bands;
      logic [15:0] right_x;
      logic [15:0] right_y;
      logic [15:0] left_x;
      logic [15:0] left_y;
      logic [7:0]  color;
   } cmd_type;

   typedef struct packed {
      logic [10:0] screen_width;
      logic [10:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic       span_valid;
      logic [9:0] span_start;
      logic [9:0] span_end;
      logic [9:0] span_row;
      logic [7:0] span_color;
      logic       band_done;
      logic       poly_done;
   } rsp_type;

endpackage

>>> sv/qssr_div.sv
module qssr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [14:0] quotient
);

   logic [3:0]  count_ff, count_in;
   logic [15:0] rem_ff, rem_in;
   logic [14:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic [16:0] rem_shift;
   logic        fits;

   assign rem_shift = {rem_ff, quo_ff[qssr_pkg::DIV_BITS-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};

   always_comb begin
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         count_in = 4'(qssr_pkg::DIV_BITS);
         rem_in   = '0;
         quo_in   = qssr_pkg::DIV_DIVIDEND;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         // one restoring step per cycle
         count_in = count_ff - 4'd1;
         rem_in   = fits ? 16'(rem_shift - {1'b0, div_ff}) : rem_shift[15:0];
         quo_in   = {quo_ff[13:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = (count_ff == '0);
   assign quotient = quo_ff;

endmodule

>>> sv/qssr_front.sv
module qssr_front #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [6:0]            req_vertex_count,
   input  logic signed [15:0]    req_right_x,
   input  logic signed [15:0]    req_right_y,
   input  logic signed [15:0]    req_left_x,
   input  logic signed [15:0]    req_left_y,
   input  logic [7:0]            req_fill_color,
   output logic                  cmd_valid,
   output qssr_pkg::cmd_type     cmd,
   input  logic                  cmd_pop
);

   localparam int CLOG_W = $clog2(MAX_VERTICES + 1);
   localparam int NW     = (CLOG_W > 7) ? CLOG_W : 7;

   qssr_pkg::cmd_type q_ff [qssr_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   qssr_pkg::cmd_type entry;
   logic [NW-1:0]     n_raw, n_clamped, n_half;

   assign req_ready = (count_ff != 2'(qssr_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   // classify the request and work out the band count for begin items
   always_comb begin
      n_raw     = NW'(req_vertex_count);
      n_clamped = (n_raw > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : n_raw;
      n_half    = n_clamped >> 1;
      entry.bands   = (n_half >= NW'(2)) ? 6'(n_half - NW'(1)) : 6'd0;
      entry.right_x = req_right_x;
      entry.right_y = req_right_y;
      entry.left_x  = req_left_x;
      entry.left_y  = req_left_y;
      entry.color   = req_fill_color;
      unique case (req_type)
         qssr_pkg::REQ_BEGIN: entry.op = qssr_pkg::OP_BEGIN;
         qssr_pkg::REQ_EDGE:  entry.op = qssr_pkg::OP_EDGE;
         qssr_pkg::REQ_ROW:   entry.op = qssr_pkg::OP_ROW;
         default:             entry.op = qssr_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

>>> sv/qssr_back.sv
module qssr_back (
   input  logic              clock,
   input  logic              reset,
   input  qssr_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  qssr_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qssr_pkg::rsp_type rsp
);

   qssr_pkg::back_state_type state_ff, state_in;

   logic [31:0] left_acc_ff, left_acc_in, right_acc_ff, right_acc_in;
   logic [31:0] left_step_ff, left_step_in, right_step_ff, right_step_in;
   logic [15:0] rows_left_ff, rows_left_in, current_row_ff, current_row_in;
   logic [5:0]  bands_left_ff, bands_left_in;
   logic [15:0] prev_lx_ff, prev_lx_in, prev_ly_ff, prev_ly_in;
   logic [15:0] prev_rx_ff, prev_rx_in, prev_ry_ff, prev_ry_in;
   logic [7:0]  held_color_ff, held_color_in;
   logic        finished_ff, finished_in;
   logic [16:0] dx_l_ff, dx_l_in, dx_r_ff, dx_r_in;
   logic        rsp_valid_ff, rsp_valid_in;
   qssr_pkg::rsp_type rsp_ff, rsp_in;

   logic        out_free, edge_active, div_start, rsp_load;
   logic [15:0] dy_l, dy_r, divisor_l, divisor_r;
   logic        div_done_l, div_done_r;
   logic [14:0] quo_l, quo_r;
   logic signed [32:0] prod_l, prod_r;
   logic [10:0] w, h;
   logic [15:0] a, b, row_next;
   logic        a_lt_w, b_ge_w;
   logic [9:0]  a_c, b_c;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign edge_active = (cmd.op == qssr_pkg::OP_EDGE) && !finished_ff && (rows_left_ff == '0);
   assign dy_l        = cmd.left_y - prev_ly_ff;
   assign dy_r        = cmd.right_y - prev_ry_ff;
   assign divisor_l   = (dy_l <= 16'd1) ? 16'd1 : dy_l;
   assign divisor_r   = (dy_r <= 16'd1) ? 16'd1 : dy_r;
   assign div_start   = (state_ff == qssr_pkg::ST_IDLE) && cmd_valid && edge_active;

   qssr_div u_div_l (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (divisor_l),
      .done     (div_done_l),
      .quotient (quo_l)
   );

   qssr_div u_div_r (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (divisor_r),
      .done     (div_done_r),
      .quotient (quo_r)
   );

   assign prod_l = $signed(dx_l_ff) * $signed({1'b0, quo_l});
   assign prod_r = $signed(dx_r_ff) * $signed({1'b0, quo_r});

   // screen size clamped to the legal range
   assign w = (cfg.screen_width == '0) ? qssr_pkg::DIM_MIN :
              (cfg.screen_width > qssr_pkg::DIM_MAX) ? qssr_pkg::DIM_MAX : cfg.screen_width;
   assign h = (cfg.screen_height == '0) ? qssr_pkg::DIM_MIN :
              (cfg.screen_height > qssr_pkg::DIM_MAX) ? qssr_pkg::DIM_MAX : cfg.screen_height;

   assign a        = left_acc_ff[31:16];
   assign b        = right_acc_ff[31:16];
   assign a_lt_w   = $signed({a[15], a}) < $signed({6'b0, w});
   assign b_ge_w   = $signed({b[15], b}) >= $signed({6'b0, w});
   assign a_c      = a[15] ? 10'd0 : a[9:0];
   assign b_c      = b_ge_w ? 10'(w - 11'd1) : b[9:0];
   assign row_next = current_row_ff + 16'd1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qssr_pkg::ST_IDLE: if (cmd_valid && edge_active) state_in = qssr_pkg::ST_DIV;
         qssr_pkg::ST_DIV:  if (div_done_l && div_done_r) state_in = qssr_pkg::ST_MUL;
         qssr_pkg::ST_MUL:  state_in = qssr_pkg::ST_FIN;
         qssr_pkg::ST_FIN:  if (out_free) state_in = qssr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      left_acc_in    = left_acc_ff;
      right_acc_in   = right_acc_ff;
      left_step_in   = left_step_ff;
      right_step_in  = right_step_ff;
      rows_left_in   = rows_left_ff;
      current_row_in = current_row_ff;
      bands_left_in  = bands_left_ff;
      prev_lx_in     = prev_lx_ff;
      prev_ly_in     = prev_ly_ff;
      prev_rx_in     = prev_rx_ff;
      prev_ry_in     = prev_ry_ff;
      held_color_in  = held_color_ff;
      finished_in    = finished_ff;
      dx_l_in        = dx_l_ff;
      dx_r_in        = dx_r_ff;
      cmd_pop        = 1'b0;
      rsp_load       = 1'b0;
      rsp_in         = '0;

      unique case (state_ff)
         qssr_pkg::ST_IDLE: begin
            if (cmd_valid && edge_active) begin
               cmd_pop       = 1'b1;
               dx_l_in       = 17'($signed(cmd.left_x) - $signed(prev_lx_ff));
               dx_r_in       = 17'($signed(cmd.right_x) - $signed(prev_rx_ff));
               prev_lx_in    = cmd.left_x;
               prev_ly_in    = cmd.left_y;
               prev_rx_in    = cmd.right_x;
               prev_ry_in    = cmd.right_y;
               bands_left_in = bands_left_ff - 6'd1;
               left_acc_in   = (left_acc_ff & qssr_pkg::ACC_INT_MASK) |
                               {16'h0, qssr_pkg::LEFT_FRAC};
               right_acc_in  = (right_acc_ff & qssr_pkg::ACC_INT_MASK) |
                               {16'h0, qssr_pkg::RIGHT_FRAC};
               // hold the band height here; zero means an empty band
               rows_left_in  = dy_r;
            end else if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               rsp_load = 1'b1;
               case (cmd.op)
                  qssr_pkg::OP_BEGIN: begin
                     bands_left_in  = cmd.bands;
                     held_color_in  = cmd.color;
                     prev_rx_in     = cmd.right_x;
                     prev_ry_in     = cmd.right_y;
                     prev_lx_in     = cmd.left_x;
                     prev_ly_in     = cmd.left_y;
                     current_row_in = ($signed(cmd.right_y) < $signed(cmd.left_y)) ?
                                      cmd.right_y : cmd.left_y;
                     left_acc_in    = {cmd.left_x, 16'h0};
                     right_acc_in   = {cmd.right_x, 16'h0};
                     left_step_in   = '0;
                     right_step_in  = '0;
                     rows_left_in   = '0;
                     finished_in    = (cmd.bands == '0);
                  end
                  qssr_pkg::OP_ROW: begin
                     if (!finished_ff && rows_left_ff != '0) begin
                        if (!current_row_ff[15] && a_lt_w && !b[15]) begin
                           rsp_in.span_valid = 1'b1;
                           rsp_in.span_start = (a_c < b_c) ? a_c : b_c;
                           rsp_in.span_end   = (a_c < b_c) ? b_c : a_c;
                           rsp_in.span_row   = current_row_ff[9:0];
                        end
                        left_acc_in    = left_acc_ff + left_step_ff;
                        right_acc_in   = right_acc_ff + right_step_ff;
                        current_row_in = row_next;
                        rows_left_in   = rows_left_ff - 16'd1;
                        if ($signed({row_next[15], row_next}) >= $signed({6'b0, h})) begin
                           finished_in  = 1'b1;
                           rows_left_in = '0;
                        end else if (rows_left_ff == 16'd1 && bands_left_ff == '0) begin
                           finished_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     // ignored edge or unused code: status only
                  end
               endcase
            end
         end
         qssr_pkg::ST_DIV: begin
         end
         qssr_pkg::ST_MUL: begin
            left_step_in  = {prod_l[29:0], 2'b00};
            right_step_in = {prod_r[29:0], 2'b00};
         end
         qssr_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (rows_left_ff == '0) begin
                  left_acc_in  = left_acc_ff + left_step_ff;
                  right_acc_in = right_acc_ff + right_step_ff;
                  if (bands_left_ff == '0) begin
                     finished_in = 1'b1;
                  end
               end
            end
         end
      endcase

      rsp_in.span_color = held_color_in;
      rsp_in.band_done  = (rows_left_in == '0);
      rsp_in.poly_done  = finished_in;
      rsp_valid_in      = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= qssr_pkg::ST_IDLE;
         rows_left_ff  <= '0;
         bands_left_ff <= '0;
         held_color_ff <= '0;
         finished_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rows_left_ff  <= rows_left_in;
         bands_left_ff <= bands_left_in;
         held_color_ff <= held_color_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      left_acc_ff    <= left_acc_in;
      right_acc_ff   <= right_acc_in;
      left_step_ff   <= left_step_in;
      right_step_ff  <= right_step_in;
      current_row_ff <= current_row_in;
      prev_lx_ff     <= prev_lx_in;
      prev_ly_ff     <= prev_ly_in;
      prev_rx_ff     <= prev_rx_in;
      prev_ry_ff     <= prev_ry_in;
      dx_l_ff        <= dx_l_in;
      dx_r_ff        <= dx_r_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> sv/quad_strip_span_rasterizer_core.sv
// Quad-strip span walker. Begin, row and ignored items are handled in the idle state of the
// back end; an edge item that opens a band starts the two 15-step reciprocal dividers
// (0x4000 / dy) that run side by side, waits while they run, then passes through one
// multiply state and one finish state.
// A two-entry queue sits between the request decoder and the walker, and a result register
// holds each reply, so requests keep flowing while a result waits to be taken. Every item
// gives exactly one result. Screen width and height sit at byte addresses 0 and 4.
`include "quad_strip_span_rasterizer_core_macros.svh"

module quad_strip_span_rasterizer_core #(
   parameter int MAX_VERTICES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [6:0]         req_vertex_count,
   input  logic signed [15:0] req_right_x,
   input  logic signed [15:0] req_right_y,
   input  logic signed [15:0] req_left_x,
   input  logic signed [15:0] req_left_y,
   input  logic [7:0]         req_fill_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_span_valid,
   output logic [9:0]         rsp_span_start,
   output logic [9:0]         rsp_span_end,
   output logic [9:0]         rsp_span_row,
   output logic [7:0]         rsp_span_color,
   output logic               rsp_band_done,
   output logic               rsp_poly_done,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [10:0]       screen_width_ff, screen_width_in;
   logic [10:0]       screen_height_ff, screen_height_in;
   logic              csr_write;
   qssr_pkg::cfg_type cfg;
   qssr_pkg::cmd_type cmd;
   qssr_pkg::rsp_type rsp;
   logic              cmd_valid, cmd_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            qssr_pkg::CSR_SCREEN_WIDTH:  screen_width_in  = pwdata[10:0];
            qssr_pkg::CSR_SCREEN_HEIGHT: screen_height_in = pwdata[10:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         qssr_pkg::CSR_SCREEN_WIDTH:  prdata = {21'b0, screen_width_ff};
         qssr_pkg::CSR_SCREEN_HEIGHT: prdata = {21'b0, screen_height_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= qssr_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= qssr_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   assign cfg.screen_width  = screen_width_ff;
   assign cfg.screen_height = screen_height_ff;

   qssr_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_vertex_count (req_vertex_count),
      .req_right_x      (req_right_x),
      .req_right_y      (req_right_y),
      .req_left_x       (req_left_x),
      .req_left_y       (req_left_y),
      .req_fill_color   (req_fill_color),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   qssr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_span_valid = rsp.span_valid;
   assign rsp_span_start = rsp.span_start;
   assign rsp_span_end   = rsp.span_end;
   assign rsp_span_row   = rsp.span_row;
   assign rsp_span_color = rsp.span_color;
   assign rsp_band_done  = rsp.band_done;
   assign rsp_poly_done  = rsp.poly_done;

   `QSSR_ASSERT_IMPLY(a_span_ordered, rsp_valid && rsp_span_valid, rsp_span_start <= rsp_span_end, "span start above span end")
   `QSSR_ASSERT_IMPLY(a_no_span_zero, rsp_valid && !rsp_span_valid, rsp_span_start == 10'd0 && rsp_span_end == 10'd0 && rsp_span_row == 10'd0, "empty result carries span data")
   `QSSR_ASSERT_IMPLY(a_reset_empty, $past(reset), !rsp_valid, "result pending right after reset")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_VERTS = 64;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_ITEMS = 110;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [6:0]  vcount;
      logic [15:0] rx;
      logic [15:0] ry;
      logic [15:0] lx;
      logic [15:0] ly;
      logic [7:0]  color;
   } strip_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = qssr_pkg::REQ_ROW;
   logic [6:0]  req_vertex_count = '0;
   logic [15:0] req_right_x = '0;
   logic [15:0] req_right_y = '0;
   logic [15:0] req_left_x = '0;
   logic [15:0] req_left_y = '0;
   logic [7:0]  req_fill_color = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_span_valid;
   logic [9:0]  rsp_span_start;
   logic [9:0]  rsp_span_end;
   logic [9:0]  rsp_span_row;
   logic [7:0]  rsp_span_color;
   logic        rsp_band_done;
   logic        rsp_poly_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   quad_strip_span_rasterizer_core #(.MAX_VERTICES(MAX_VERTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_vertex_count(req_vertex_count),
      .req_right_x(req_right_x), .req_right_y(req_right_y),
      .req_left_x(req_left_x), .req_left_y(req_left_y),
      .req_fill_color(req_fill_color),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_span_valid(rsp_span_valid), .rsp_span_start(rsp_span_start),
      .rsp_span_end(rsp_span_end), .rsp_span_row(rsp_span_row),
      .rsp_span_color(rsp_span_color), .rsp_band_done(rsp_band_done),
      .rsp_poly_done(rsp_poly_done),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // walker shadow state and screen size
   logic [10:0] scr_w = qssr_pkg::SCREEN_WIDTH_RESET;
   logic [10:0] scr_h = qssr_pkg::SCREEN_HEIGHT_RESET;
   logic [31:0] l_acc = '0, r_acc = '0, l_stp = '0, r_stp = '0;
   logic [15:0] rows_rem = '0, cur_row = '0;
   logic [5:0]  bands_rem = '0;
   logic [15:0] pl_x = '0, pl_y = '0, pr_x = '0, pr_y = '0;
   logic [7:0]  color_q = '0;
   bit          poly_end = 1'b1;

   strip_item_type    pending_items[$];
   qssr_pkg::rsp_type expected_spans[$];

   bit req_xfer = 1'b0;
   int errors = 0;
   int transfers_in = 0;
   int results_seen = 0;
   int spans_seen = 0;
   int settings_used = 0;
   int queued_items = 0;

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int any16();
      return pick(-32768, 32767);
   endfunction

   function automatic int dim_of(logic [10:0] v);
      if (v < qssr_pkg::DIM_MIN) return 1;
      if (v > qssr_pkg::DIM_MAX) return 1024;
      return int'(v);
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = pick(0, 99);
      if (r < 55) return 0;
      if (r < 85) return pick(1, 3);
      if (r < 97) return pick(4, 12);
      return pick(20, 40);
   endfunction

   // 16.16 edge increment over one band, dy returned modulo 2^16
   function automatic logic [31:0] edge_slope(input logic [15:0] ax, ay, bx, by,
                                              output logic [15:0] dy);
      logic [15:0] d;
      logic [31:0] div;
      logic [31:0] q;
      int dx;
      d = by - ay;
      div = (d <= 16'd1) ? 32'd1 : {16'd0, d};
      dx = int'($signed(bx)) - int'($signed(ax));
      q = {17'd0, qssr_pkg::DIV_DIVIDEND} / div;
      dy = d;
      return (32'(dx) * q) << 2;
   endfunction

   task automatic rasterize_item(input logic [1:0] kind, input logic [6:0] vcount,
                                 input logic [15:0] rx, ry, lx, ly,
                                 input logic [7:0] col);
      qssr_pkg::rsp_type span;
      logic [15:0] hl, hr;
      int n, w, h, y, a, b;
      span = '0;
      if (kind == qssr_pkg::REQ_BEGIN) begin
         n = vcount;
         if (n > MAX_VERTS) n = MAX_VERTS;
         n = n / 2;
         bands_rem = 6'((n >= 2) ? n - 1 : 0);
         color_q = col;
         pr_x = rx; pr_y = ry;
         pl_x = lx; pl_y = ly;
         cur_row = ($signed(ry) < $signed(ly)) ? ry : ly;
         l_acc = {lx, 16'h0};
         r_acc = {rx, 16'h0};
         l_stp = '0;
         r_stp = '0;
         rows_rem = '0;
         poly_end = (bands_rem == 0);
      end else if (kind == qssr_pkg::REQ_EDGE) begin
         if (!poly_end && rows_rem == 0) begin
            l_stp = edge_slope(pl_x, pl_y, lx, ly, hl);
            r_stp = edge_slope(pr_x, pr_y, rx, ry, hr);
            pl_x = lx; pl_y = ly;
            pr_x = rx; pr_y = ry;
            bands_rem = bands_rem - 6'd1;
            l_acc = (l_acc & qssr_pkg::ACC_INT_MASK) | {16'h0, qssr_pkg::LEFT_FRAC};
            r_acc = (r_acc & qssr_pkg::ACC_INT_MASK) | {16'h0, qssr_pkg::RIGHT_FRAC};
            if (hr == 0) begin
               // flat band: advance once and close it
               l_acc = l_acc + l_stp;
               r_acc = r_acc + r_stp;
               rows_rem = '0;
               if (bands_rem == 0) poly_end = 1'b1;
            end else begin
               rows_rem = hr;
            end
         end
      end else if (kind == qssr_pkg::REQ_ROW) begin
         if (!poly_end && rows_rem != 0) begin
            w = dim_of(scr_w);
            h = dim_of(scr_h);
            y = int'($signed(cur_row));
            if (y >= 0) begin
               a = int'($signed(l_acc[31:16]));
               b = int'($signed(r_acc[31:16]));
               if (a < w && b >= 0) begin
                  if (a < 0) a = 0;
                  if (b >= w) b = w - 1;
                  span.span_valid = 1'b1;
                  span.span_start = 10'((a < b) ? a : b);
                  span.span_end = 10'((a < b) ? b : a);
                  span.span_row = 10'(y);
               end
            end
            l_acc = l_acc + l_stp;
            r_acc = r_acc + r_stp;
            cur_row = cur_row + 16'd1;
            rows_rem = rows_rem - 16'd1;
            if (int'($signed(cur_row)) >= h) begin
               poly_end = 1'b1;
               rows_rem = '0;
            end else if (rows_rem == 0) begin
               if (bands_rem == 0) poly_end = 1'b1;
            end
         end
      end
      span.span_color = color_q;
      span.band_done = (rows_rem == 0);
      span.poly_done = poly_end;
      expected_spans.push_back(span);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      qssr_pkg::rsp_type want;
      req_xfer = 1'b0;
      if (!reset) begin
         req_xfer = req_valid && req_ready;
         if (req_xfer) begin
            rasterize_item(req_type, req_vertex_count, req_right_x, req_right_y,
                           req_left_x, req_left_y, req_fill_color);
            transfers_in++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_spans.size() == 0) begin
               $error("result transfer with no span expected");
               errors++;
            end else begin
               want = expected_spans.pop_front();
               compare_field("span_valid", want.span_valid, rsp_span_valid);
               compare_field("span_start", want.span_start, rsp_span_start);
               compare_field("span_end", want.span_end, rsp_span_end);
               compare_field("span_row", want.span_row, rsp_span_row);
               compare_field("span_color", want.span_color, rsp_span_color);
               compare_field("band_done", want.band_done, rsp_band_done);
               compare_field("poly_done", want.poly_done, rsp_poly_done);
               if (rsp_span_valid) spans_seen++;
            end
         end
      end
   end

   int gap_left = 0;
   int calm_req = 0;

   always @(negedge clock) begin
      strip_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         // hold anything not yet transferred, otherwise idle or load the next item
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_type <= it.kind;
            req_vertex_count <= it.vcount;
            req_right_x <= it.rx;
            req_right_y <= it.ry;
            req_left_x <= it.lx;
            req_left_y <= it.ly;
            req_fill_color <= it.color;
            req_valid <= 1'b1;
            if (calm_req > 0) calm_req--;
            else if (pick(0, 59) == 0) calm_req = pick(30, 80);
            else gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   int stall_left = 0;
   int calm_rsp = 0;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_rsp > 0) calm_rsp--;
         else if (pick(0, 49) == 0) calm_rsp = pick(40, 120);
         else if (pick(0, 2) == 0) stall_left = pick_gap();
      end
   end

   task automatic add_item(input logic [1:0] kind, input int vc, rx, ry, lx, ly, col);
      strip_item_type it;
      it.kind = kind;
      it.vcount = 7'(vc);
      it.rx = 16'(rx);
      it.ry = 16'(ry);
      it.lx = 16'(lx);
      it.ly = 16'(ly);
      it.color = 8'(col);
      pending_items.push_back(it);
      queued_items++;
   endtask

   task automatic add_noise();
      case (pick(0, 3))
         0: add_item(REQ_UNUSED, pick(0, 127), any16(), any16(), any16(), any16(),
                     pick(0, 255));
         1: add_item(2'($urandom), pick(0, 127), any16(), any16(), any16(), any16(),
                     pick(0, 255));
         2: add_item(qssr_pkg::REQ_ROW, pick(0, 127), any16(), any16(), any16(), any16(),
                     pick(0, 255));
         default: add_item(qssr_pkg::REQ_EDGE, pick(0, 127), any16(), any16(), any16(),
                           any16(), pick(0, 255));
      endcase
   endtask

   // one strip: begin, then per band an edge and its row ticks, with occasional noise items and spare row ticks
   task automatic add_polygon(input int w, input int h);
      int nb, vc, y0, rx, ry, lx, ly, dyr, dyl, rows, r;
      r = pick(0, 9);
      nb = (r < 6) ? pick(1, 3) : (r < 9) ? pick(4, 8) : pick(9, 31);
      vc = 2 * (nb + 1);
      r = pick(0, 19);
      if (r == 0) vc = pick(65, 127);
      else if (r < 3) vc = vc + 1;
      y0 = (pick(0, 5) == 0) ? h - pick(1, 10) : pick(-8, h - 4);
      rx = pick(-30, w + 30);
      lx = pick(-30, w + 30);
      ry = y0;
      ly = (pick(0, 3) == 0) ? y0 + pick(0, 3) : y0;
      add_item(qssr_pkg::REQ_BEGIN, vc, rx, ry, lx, ly, pick(0, 255));
      for (int k = 0; k < nb; k++) begin
         r = pick(0, 99);
         dyr = (r < 8) ? 0 : (r < 80) ? pick(1, 8) : (r < 95) ? pick(9, 30) :
               (r < 98) ? pick(100, 3000) : pick(-50, -1);
         dyl = (pick(0, 3) == 0) ? pick(-10, 20) : dyr;
         rx += (pick(0, 9) == 0) ? pick(-400, 400) : pick(-20, 20);
         lx += (pick(0, 9) == 0) ? pick(-400, 400) : pick(-20, 20);
         ry += dyr;
         ly += dyl;
         add_item(qssr_pkg::REQ_EDGE, pick(0, 127), rx, ry, lx, ly, pick(0, 255));
         rows = (dyr < 0) ? dyr + 65536 : dyr;
         if (rows > 40) rows = pick(5, 40);
         for (int j = 0; j < rows; j++) begin
            add_item(qssr_pkg::REQ_ROW, pick(0, 127), any16(), any16(), any16(), any16(),
                     pick(0, 255));
            if (pick(0, 59) == 0) add_noise();
         end
         if (pick(0, 29) == 0)
            add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_spans.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [10:0] value);
      string name;
      logic [31:0] rd;
      name = (idx == qssr_pkg::CSR_SCREEN_WIDTH) ? "screen_width" : "screen_height";
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {21'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == qssr_pkg::CSR_SCREEN_WIDTH) scr_w = value;
      else scr_h = value;
      // read it back
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      compare_field(name, value, rd);
   endtask

   int phase_w[7] = '{0, 1, 1024, 2047, 64, 0, 320};
   int phase_h[7] = '{0, 1, 1024, 2047, 48, 0, 200};

   initial begin
      int w, h, start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle row, idle edge, unused code, too few vertices
      add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      add_item(qssr_pkg::REQ_EDGE, 0, 5, 5, 5, 5, 0);
      add_item(REQ_UNUSED, 127, -1, -1, -1, -1, 255);
      add_item(qssr_pkg::REQ_BEGIN, 2, 10, 10, 20, 10, 0);
      // oversized count, extreme x, rows above the screen, edge while a band runs
      add_item(qssr_pkg::REQ_BEGIN, 127, -32768, -3, 32767, -3, 8'hA5);
      add_item(qssr_pkg::REQ_EDGE, 0, 32767, 5, -32768, 5, 0);
      add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      add_item(qssr_pkg::REQ_EDGE, 0, 0, 40, 0, 40, 0);
      // right edge runs off the screen, extra tick after the polygon ends
      add_item(qssr_pkg::REQ_BEGIN, 4, 300, 10, 10, 10, 8'h3C);
      add_item(qssr_pkg::REQ_EDGE, 0, 400, 12, -20, 12, 0);
      repeat (3) add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      // odd count, swapped sides, flat band, walk into the screen bottom
      add_item(qssr_pkg::REQ_BEGIN, 7, 5, 195, 100, 195, 8'hFF);
      add_item(qssr_pkg::REQ_EDGE, 0, 50, 195, 120, 197, 0);
      add_item(qssr_pkg::REQ_EDGE, 0, 60, 205, 130, 205, 0);
      repeat (5) add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      // row counter wraps from the top positive row
      add_item(qssr_pkg::REQ_BEGIN, 4, 0, 32767, 0, 32767, 8'h5A);
      add_item(qssr_pkg::REQ_EDGE, 0, 10, -32768, 3, -32768, 0);
      add_item(qssr_pkg::REQ_ROW, 0, 0, 0, 0, 0, 0);
      wait_idle();

      for (int p = 0; p < 7; p++) begin
         w = phase_w[p];
         h = phase_h[p];
         if (p == 5) begin
            w = pick(1, 1024);
            h = pick(1, 1024);
         end
         csr_write(qssr_pkg::CSR_SCREEN_WIDTH, 11'(w));
         csr_write(qssr_pkg::CSR_SCREEN_HEIGHT, 11'(h));
         settings_used++;
         start = queued_items;
         while (queued_items - start < PHASE_ITEMS)
            add_polygon(dim_of(11'(w)), dim_of(11'(h)));
         wait_idle();
      end

      $display("Run covered %0d request transfers and %0d checked results (%0d visible spans)",
               transfers_in, results_seen, spans_seen);
      $display("over the reset screen size and %0d written screen sizes.", settings_used);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $error("timeout: %0d spans still expected", expected_spans.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
